>>> rtl/psfg_pkg.sv
// Shared constants, types and sine table builder for the positive sine frame generator.
package psfg_pkg;

    // Frame and field widths
    localparam int FRAME_LEN  = 256;
    localparam int POS_W      = $clog2(FRAME_LEN);
    localparam int CNT_W      = 9;
    localparam int AMP_W      = 11;
    localparam int VAL_W      = 12;

    // Sine table geometry
    localparam int SINE_STEPS     = 1024;
    localparam int PHASE_W        = $clog2(SINE_STEPS);
    localparam int HALF_STEPS     = SINE_STEPS / 2;
    localparam int QTR_STEPS      = SINE_STEPS / 4;
    localparam int QTR_W          = $clog2(QTR_STEPS + 1);
    localparam int SINE_FRAC_BITS = 15;
    localparam int MAG_W          = SINE_FRAC_BITS;
    localparam int OFFS_W         = SINE_FRAC_BITS + 1;
    localparam int PROD_W         = AMP_W + OFFS_W;
    localparam int SINE_TERMS     = 14;
    localparam logic [63:0] SINE_SCALE  = (64'd1 << SINE_FRAC_BITS) - 64'd1;
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
    localparam logic [OFFS_W-1:0] OFFS_ONE   = OFFS_W'(1) << SINE_FRAC_BITS;
    localparam logic [PROD_W:0]   ROUND_HALF = (PROD_W + 1)'(1) << (SINE_FRAC_BITS - 1);

    // Shared divider geometry
    localparam int DIV_W      = PHASE_W;
    localparam int DIV_STEP_W = $clog2(DIV_W + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = AMP_W;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_COUNT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_AMPLITUDE = 1'd1;
    localparam logic [CNT_W-1:0]     CC_RESET           = 9'd1;
    localparam logic [AMP_W-1:0]     AMP_RESET          = 11'd511;

    // One classified word on its way from the front to the back
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             last;
    } frm_item_t;

    // Divider request and response
    typedef struct packed {
        logic                  start;
        logic [DIV_STEP_W-1:0] steps;
        logic [DIV_W-1:0]      dividend;
        logic [CNT_W-1:0]      rem_init;
        logic [CNT_W-1:0]      divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [CNT_W-1:0] rem;
    } div_rsp_t;

    typedef logic [QTR_STEPS:0][MAG_W-1:0] qsin_tab_t;

    // (a*b) >> 62 for Q62 operands
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Unsigned 64-bit quotient by shift and subtract
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        int          i;
        q   = '0;
        rem = '0;
        for (i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Rounded quarter-wave sine magnitude at step u of QTR_STEPS
    function automatic logic [MAG_W-1:0] sine_mag(input int u);
        logic [63:0] r;
        logic [63:0] ang;
        logic [63:0] a2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] den;
        logic [63:0] s40;
        logic [63:0] mag;
        int          k;
        r    = 64'(u) << (62 - $clog2(QTR_STEPS));
        ang  = mul_q62(r, HALF_PI_Q62);
        a2   = mul_q62(ang, ang);
        term = ang;
        sum  = ang;
        for (k = 1; k <= SINE_TERMS; k++)
        begin
            den  = 64'(2 * k) * 64'(2 * k + 1);
            term = div_u64(mul_q62(term, a2), den);
            if ((k % 2) == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        s40 = sum >> 22;
        mag = (SINE_SCALE * s40 + (64'd1 << 39)) >> 40;
        return mag[MAG_W-1:0];
    endfunction

    // Build the quarter-wave table at elaboration
    function automatic qsin_tab_t build_qsin_tab();
        qsin_tab_t tab;
        int        u;
        for (u = 0; u <= QTR_STEPS; u++)
        begin
            tab[u] = sine_mag(u);
        end
        return tab;
    endfunction

endpackage

>>> rtl/psfg_if.sv
// Request and sample channel interfaces of the positive sine frame generator.
interface psfg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface psfg_out_if;
    import psfg_pkg::*;

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] sample_value;
    logic [POS_W-1:0] sample_index;
    logic             in_wave;
    logic             frame_end;

    modport source (output valid, output sample_value, output sample_index,
                    output in_wave, output frame_end, input ready);
    modport sink   (input valid, input sample_value, input sample_index,
                    input in_wave, input frame_end, output ready);
endinterface

>>> rtl/psfg_div.sv
// Shared restoring divider, one quotient bit per cycle.
module psfg_div (
    input  logic                clk,
    input  logic                rst_n,
    input  psfg_pkg::div_req_t  req,
    output psfg_pkg::div_rsp_t  rsp
);
    import psfg_pkg::*;

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [DIV_STEP_W-1:0] cnt_reg;
    logic [DIV_STEP_W-1:0] cnt_next;
    logic [DIV_W-1:0]      dq_reg;
    logic [DIV_W-1:0]      dq_next;
    logic [CNT_W-1:0]      rem_reg;
    logic [CNT_W-1:0]      rem_next;
    logic [CNT_W-1:0]      dvsr_reg;
    logic [CNT_W-1:0]      dvsr_next;
    logic [CNT_W:0]        shifted;
    logic [CNT_W:0]        diff;
    logic                  ge;

    // Shift in the next dividend bit and try the subtract
    always_comb
    begin
        shifted = {rem_reg, dq_reg[DIV_W-1]};
        diff    = shifted - {1'b0, dvsr_reg};
        ge      = shifted >= {1'b0, dvsr_reg};
    end

    // Load on start, step while busy
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            dq_next   = req.dividend;
            rem_next  = req.rem_init;
            dvsr_next = req.divisor;
        end
        else if (busy_reg)
        begin
            dq_next  = {dq_reg[DIV_W-2:0], ge};
            rem_next = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = dq_reg;
    assign rsp.rem  = rem_reg;

endmodule

>>> rtl/psfg_front.sv
// Front end: accepts request words and assigns each its frame position.
module psfg_front (
    input  logic                clk,
    input  logic                rst_n,
    psfg_in_if.sink             sample_req,
    input  logic                full,
    output logic                push,
    output psfg_pkg::frm_item_t item
);
    import psfg_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] k;

    // Take a word whenever the queue has room
    assign sample_req.ready = !full;
    assign push             = sample_req.valid && !full;

    // Classify: position in frame and last-sample flag
    always_comb
    begin
        k         = sample_req.restart ? '0 : pos_reg;
        item.pos  = k;
        item.last = (k == POS_W'(FRAME_LEN - 1));
        pos_next  = pos_reg;
        if (push)
            pos_next = item.last ? '0 : k + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule

>>> rtl/psfg_queue.sv
// Two-entry queue between the front and the back.
module psfg_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  psfg_pkg::frm_item_t push_item,
    input  logic                pop,
    output psfg_pkg::frm_item_t pop_item,
    output logic                empty,
    output logic                full
);
    import psfg_pkg::*;

    localparam int PTR_W = 1;
    localparam int DEPTH = 2 ** PTR_W;

    frm_item_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (PTR_W + 1)'(DEPTH));
    assign pop_item = mem[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

>>> rtl/psfg_back.sv
// Back end: cycle length, phase, table lookup, scaling and the output register.
module psfg_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [psfg_pkg::CNT_W-1:0]  cycle_count,
    input  logic [psfg_pkg::AMP_W-1:0]  wave_amplitude,
    input  logic                        len_clear,
    input  logic                        item_avail,
    input  psfg_pkg::frm_item_t         item,
    output logic                        item_pop,
    output psfg_pkg::div_req_t          div_req,
    input  psfg_pkg::div_rsp_t          div_rsp,
    psfg_out_if.source                  sample_rsp
);
    import psfg_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LEN   = 3'd1;
    localparam logic [2:0] ST_QUOT  = 3'd2;
    localparam logic [2:0] ST_PHASE = 3'd3;
    localparam logic [2:0] ST_LOOK  = 3'd4;
    localparam logic [2:0] ST_MUL   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    localparam qsin_tab_t QSIN_TAB = build_qsin_tab();

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [CNT_W-1:0]   len_reg;
    logic [CNT_W-1:0]   len_next;
    logic               len_ok_reg;
    logic               len_ok_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic               last_reg;
    logic               last_next;
    logic               wave_reg;
    logic               wave_next;
    logic [PHASE_W-1:0] t_reg;
    logic [PHASE_W-1:0] t_next;
    logic [MAG_W-1:0]   mag_reg;
    logic               neg_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [VAL_W-1:0]   out_value_reg;
    logic [POS_W-1:0]   out_index_reg;
    logic               out_wave_reg;
    logic               out_last_reg;

    logic               cc_ok;
    logic               load_out;
    logic [CNT_W-1:0]   n;
    logic [QTR_W-1:0]   tt;
    logic [PHASE_W-1:0] mirror;
    logic [QTR_W-1:0]   u;
    logic [OFFS_W-1:0]  offs;
    logic [PROD_W:0]    rsum;

    function automatic div_req_t make_req(input logic [DIV_STEP_W-1:0] steps,
                                          input logic [DIV_W-1:0]      dividend,
                                          input logic [CNT_W-1:0]      rem_init,
                                          input logic [CNT_W-1:0]      divisor);
        div_req_t r;
        r.start    = 1'b1;
        r.steps    = steps;
        r.dividend = dividend;
        r.rem_init = rem_init;
        r.divisor  = divisor;
        return r;
    endfunction

    // Request k / len with the position left-aligned in the dividend
    function automatic div_req_t quot_req(input logic [POS_W-1:0] pos,
                                          input logic [CNT_W-1:0] len);
        return make_req(DIV_STEP_W'(POS_W), DIV_W'(pos) << (DIV_W - POS_W), '0, len);
    endfunction

    assign cc_ok = (cycle_count != '0) && (cycle_count <= CNT_W'(FRAME_LEN));
    assign n     = div_rsp.rem + 1'b1;

    // Sequence one word through the shared divider and the datapath
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        len_ok_next    = len_clear ? 1'b0 : len_ok_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;
        wave_next      = wave_reg;
        t_next         = t_reg;
        item_pop       = 1'b0;
        div_req        = '0;
        load_out       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_avail)
                begin
                    item_pop  = 1'b1;
                    pos_next  = item.pos;
                    last_next = item.last;
                    if (!cc_ok)
                    begin
                        wave_next  = 1'b0;
                        state_next = ST_DONE;
                    end
                    else if (!len_ok_reg)
                    begin
                        div_req = make_req(DIV_STEP_W'(CNT_W),
                                           DIV_W'(FRAME_LEN) << (DIV_W - CNT_W),
                                           '0, cycle_count);
                        state_next = ST_LEN;
                    end
                    else
                    begin
                        div_req    = quot_req(item.pos, len_reg);
                        state_next = ST_QUOT;
                    end
                end
            end
            ST_LEN:
            begin
                if (div_rsp.done)
                begin
                    len_next    = div_rsp.quot[CNT_W-1:0];
                    len_ok_next = 1'b1;
                    div_req     = quot_req(pos_reg, div_rsp.quot[CNT_W-1:0]);
                    state_next  = ST_QUOT;
                end
            end
            ST_QUOT:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quot >= DIV_W'(cycle_count))
                    begin
                        wave_next  = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        wave_next = 1'b1;
                        // Last sample of a cycle wraps the phase to zero
                        if (n == len_reg)
                        begin
                            t_next     = '0;
                            state_next = ST_LOOK;
                        end
                        else
                        begin
                            div_req    = make_req(DIV_STEP_W'(PHASE_W), '0, n, len_reg);
                            state_next = ST_PHASE;
                        end
                    end
                end
            end
            ST_PHASE:
            begin
                if (div_rsp.done)
                begin
                    t_next     = div_rsp.quot[PHASE_W-1:0];
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || sample_rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Fold the phase into the first quarter wave
    always_comb
    begin
        tt     = t_reg[PHASE_W-2:0];
        mirror = PHASE_W'(HALF_STEPS) - {1'b0, tt};
        u      = (tt > QTR_W'(QTR_STEPS)) ? mirror[QTR_W-1:0] : tt;
    end

    // Offset the signed sine by one so the scaled sample stays non-negative
    always_comb
    begin
        offs = neg_reg ? OFFS_ONE - OFFS_W'(mag_reg) : OFFS_ONE + OFFS_W'(mag_reg);
        rsum = {1'b0, prod_reg} + ROUND_HALF;
    end

    assign out_valid_next = load_out ? 1'b1 :
                            (sample_rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_ok_reg    <= len_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg  <= len_next;
        pos_reg  <= pos_next;
        last_reg <= last_next;
        wave_reg <= wave_next;
        t_reg    <= t_next;
        if (state_reg == ST_LOOK)
        begin
            mag_reg <= QSIN_TAB[u];
            neg_reg <= t_reg[PHASE_W-1];
        end
        if (state_reg == ST_MUL)
            prod_reg <= PROD_W'(wave_amplitude) * PROD_W'(offs);
        if (load_out)
        begin
            out_value_reg <= wave_reg ? rsum[SINE_FRAC_BITS +: VAL_W] : '0;
            out_index_reg <= pos_reg;
            out_wave_reg  <= wave_reg;
            out_last_reg  <= last_reg;
        end
    end

    assign sample_rsp.valid        = out_valid_reg;
    assign sample_rsp.sample_value = out_value_reg;
    assign sample_rsp.sample_index = out_index_reg;
    assign sample_rsp.in_wave      = out_wave_reg;
    assign sample_rsp.frame_end    = out_last_reg;

endmodule

>>> rtl/positive_sine_frame_generator_core.sv
// Top level of the positive sine frame generator.
//
// Each word on sample_req asks for the next sample of a 256-sample frame;
// restart=1 makes that word frame sample 0. Each request gives exactly one
// word on sample_rsp: sample value, its frame index, in_wave and frame_end.
// cycle_count (index 0) and wave_amplitude (index 1) are written through
// cfg_we/cfg_index/cfg_data while no request is in flight.
// A front stage takes requests into a two-entry queue; the back stage runs
// each through one shared one-bit-per-cycle divider (k / L, then the phase
// n*1024 / L), a quarter-wave table, one 11x16 multiply and an output register.
// The last sample of a cycle skips the phase divide; a tail word also skips
// the table and multiply, and a word skips the divider too when cycle_count
// is 0 or above 256. The first word after cycle_count is written first divides
// out L = 256 / cycle_count. The back takes a new word from the queue only once
// the last is in the output register. Reset clears the frame position, the
// queue and the output register and loads cycle_count 1, wave_amplitude 511.
// When the receiver stalls, the output word holds, the back waits with its
// finished result, and the front keeps accepting until the queue is full.
module positive_sine_frame_generator_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [psfg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [psfg_pkg::CFG_DATA_W-1:0] cfg_data,
    psfg_in_if.sink                         sample_req,
    psfg_out_if.source                      sample_rsp
);
    import psfg_pkg::*;

    logic [CNT_W-1:0] cycle_count_reg;
    logic [CNT_W-1:0] cycle_count_next;
    logic [AMP_W-1:0] wave_amplitude_reg;
    logic [AMP_W-1:0] wave_amplitude_next;
    logic             len_clear;
    logic             push;
    logic             pop;
    logic             empty;
    logic             full;
    frm_item_t        push_item;
    frm_item_t        pop_item;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    // Write configuration registers
    always_comb
    begin
        cycle_count_next    = cycle_count_reg;
        wave_amplitude_next = wave_amplitude_reg;
        len_clear           = 1'b0;
        if (cfg_we)
        begin
            if (cfg_index == CFG_CYCLE_COUNT)
            begin
                cycle_count_next = cfg_data[CNT_W-1:0];
                len_clear        = 1'b1;
            end
            if (cfg_index == CFG_WAVE_AMPLITUDE)
                wave_amplitude_next = cfg_data[AMP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_count_reg    <= CC_RESET;
            wave_amplitude_reg <= AMP_RESET;
        end
        else
        begin
            cycle_count_reg    <= cycle_count_next;
            wave_amplitude_reg <= wave_amplitude_next;
        end
    end

    psfg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_req (sample_req),
        .full       (full),
        .push       (push),
        .item       (push_item)
    );

    psfg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (empty),
        .full      (full)
    );

    psfg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    psfg_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cycle_count    (cycle_count_reg),
        .wave_amplitude (wave_amplitude_reg),
        .len_clear      (len_clear),
        .item_avail     (!empty),
        .item           (pop_item),
        .item_pop       (pop),
        .div_req        (div_req),
        .div_rsp        (div_rsp),
        .sample_rsp     (sample_rsp)
    );

endmodule

>>> rtl/psfg_checker.sv
// Port-level checks of the positive sine frame generator and their binding.
module psfg_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [psfg_pkg::VAL_W-1:0]   sample_value,
    input logic [psfg_pkg::POS_W-1:0]   sample_index,
    input logic                         in_wave,
    input logic                         frame_end
);
    import psfg_pkg::*;

    // Flag the last sample exactly at the last frame index
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (frame_end == (sample_index == POS_W'(FRAME_LEN - 1))))
        else $error("frame_end does not match the last frame index");

    // Drive zero in the tail
    a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !in_wave |-> (sample_value == '0))
        else $error("tail word carries a nonzero sample");

    // Hold a stalled output word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(sample_value)
            && $stable(sample_index) && $stable(in_wave) && $stable(frame_end))
        else $error("stalled output word changed");

endmodule

bind positive_sine_frame_generator_core psfg_checker u_psfg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (sample_rsp.valid),
    .rsp_ready    (sample_rsp.ready),
    .sample_value (sample_rsp.sample_value),
    .sample_index (sample_rsp.sample_index),
    .in_wave      (sample_rsp.in_wave),
    .frame_end    (sample_rsp.frame_end)
);

>>> dv/tb_positive_sine_frame_generator_core.sv
`timescale 1ns / 100ps
// Testbench for the positive sine frame generator: directed table, random frames, per-word checks.
module tb_positive_sine_frame_generator_core;
    import psfg_pkg::*;

    // Run shape
    localparam int TOTAL_REQUESTS = 1850;
    localparam int CALM_TAIL      = 200;
    localparam int STALL_LIMIT    = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_CYCLES     = 50;

    // Frame and sine geometry of the predictor
    localparam int          FRAME_SIZE       = 256;
    localparam int          TABLE_STEPS      = 1024;
    localparam int          TABLE_STEPS_LOG  = 10;
    localparam int          FRAC_BITS        = 15;
    localparam int          SERIES_TERMS     = 14;
    localparam logic [63:0] Q15_FULL         = 64'd32767;
    localparam logic [63:0] QUARTER_TURN_Q62 = 64'h6487ED5110B4611A;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] index;
        logic             in_wave;
        logic             frame_end;
    } sample_word_t;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  restart;
        bit                    typed;
        sample_word_t          word;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    psfg_in_if  sample_req ();
    psfg_out_if sample_rsp ();

    positive_sine_frame_generator_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_req (sample_req),
        .sample_rsp (sample_rsp)
    );

    // Predictor state and configuration copy
    logic [CNT_W-1:0] cycle_count_q;
    logic [AMP_W-1:0] amplitude_q;
    logic [POS_W-1:0] frame_pos;
    int               sine_lut [TABLE_STEPS];

    sample_word_t expected_samples [$];
    int           mismatch_count = 0;
    int           quiet_cycles   = 0;
    bit           snd_idle_en    = 1'b0;
    bit           rsp_idle_en    = 1'b0;
    bit           long_hold_req  = 1'b0;

    // Q62 fixed-point product
    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[125:62];
    endfunction

    // Rounded Q1.15 sine at table step t, by Taylor series on the folded angle
    function automatic int sine_q15(input int t);
        logic [63:0] x;
        logic [63:0] ang;
        logic [63:0] a2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] mag;
        bit          neg;
        int          k;
        x   = 64'(4 * t);
        neg = 1'b0;
        if (x >= 64'(2 * TABLE_STEPS))
        begin
            x   = x - 64'(2 * TABLE_STEPS);
            neg = 1'b1;
        end
        if (x > 64'(TABLE_STEPS))
            x = 64'(2 * TABLE_STEPS) - x;
        ang  = q62_mul(x << (62 - TABLE_STEPS_LOG), QUARTER_TURN_Q62);
        a2   = q62_mul(ang, ang);
        term = ang;
        sum  = ang;
        for (k = 1; k <= SERIES_TERMS; k++)
        begin
            term = q62_mul(term, a2) / (64'(2 * k) * 64'(2 * k + 1));
            if (k % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        mag = (Q15_FULL * (sum >> 22) + (64'd1 << 39)) >> 40;
        return neg ? -int'(mag) : int'(mag);
    endfunction

    // Work out the word for one request and advance the frame position
    function automatic sample_word_t predict_sample(input logic restart_bit);
        sample_word_t w;
        int unsigned  k;
        int unsigned  span;
        int unsigned  n;
        int unsigned  t;
        longint       num;
        if (restart_bit)
            frame_pos = '0;
        k    = frame_pos;
        span = 0;
        if (cycle_count_q >= 1 && cycle_count_q <= FRAME_SIZE)
            span = FRAME_SIZE / int'(cycle_count_q);
        w       = '0;
        w.index = frame_pos;
        if (span > 0 && k < int'(cycle_count_q) * span)
        begin
            n         = k % span + 1;
            t         = (n * TABLE_STEPS / span) % TABLE_STEPS;
            num       = longint'(amplitude_q) * longint'(sine_lut[t] + (1 << FRAC_BITS))
                        + longint'(1 << (FRAC_BITS - 1));
            w.value   = VAL_W'(num >> FRAC_BITS);
            w.in_wave = 1'b1;
        end
        w.frame_end = (k == FRAME_SIZE - 1);
        frame_pos   = frame_pos + 1'b1;
        return w;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    // Rows of the directed table
    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row         = '{default: '0};
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.data    = data;
        return row;
    endfunction

    function automatic stim_row_t item_row(input logic restart_bit);
        stim_row_t row;
        row         = '{default: '0};
        row.restart = restart_bit;
        return row;
    endfunction

    function automatic stim_row_t typed_row(input logic restart_bit, input int value,
                                            input int index, input logic in_wave,
                                            input logic frame_end);
        stim_row_t row;
        row         = item_row(restart_bit);
        row.typed   = 1'b1;
        row.word    = '{VAL_W'(value), POS_W'(index), in_wave, frame_end};
        return row;
    endfunction

    // Offer one request word and hold it until taken
    task automatic send_request(input logic restart_bit, input bit typed,
                                input sample_word_t typed_word);
        sample_word_t w;
        sample_req.valid   <= 1'b1;
        sample_req.restart <= restart_bit;
        do
            @(posedge clk);
        while (!sample_req.ready);
        w = predict_sample(restart_bit);
        expected_samples.push_back(typed ? typed_word : w);
    endtask

    // Drop valid for a short random burst
    task automatic sender_gap();
        if (snd_idle_en && $urandom_range(0, 3) == 0)
        begin
            sample_req.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic drain_samples();
        sample_req.valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
    endtask

    // Write one register once the block has gone idle
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        drain_samples();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_CYCLE_COUNT)
            cycle_count_q = data[CNT_W-1:0];
        else if (idx == CFG_WAVE_AMPLITUDE)
            amplitude_q = data[AMP_W-1:0];
        @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: random stalls, one long hold-off on request
    initial
    begin
        sample_rsp.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req     = 1'b0;
                sample_rsp.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (rsp_idle_en && $urandom_range(0, 7) == 0)
            begin
                sample_rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                sample_rsp.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each sample word with the oldest expectation
    always @(posedge clk)
    begin
        sample_word_t want;
        if (rst_n && sample_rsp.valid && sample_rsp.ready)
        begin
            if (expected_samples.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected sample word, index %0d value %0d", $time,
                         sample_rsp.sample_index, sample_rsp.sample_value);
            end
            else
            begin
                want = expected_samples.pop_front();
                check_field("sample_value", want.value, sample_rsp.sample_value);
                check_field("sample_index", want.index, sample_rsp.sample_index);
                check_field("in_wave", want.in_wave, sample_rsp.in_wave);
                check_field("frame_end", want.frame_end, sample_rsp.frame_end);
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((sample_req.valid && sample_req.ready) || (sample_rsp.valid && sample_rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        stim_row_t             directed_rows [$];
        stim_row_t             row;
        logic [CFG_DATA_W-1:0] d;
        logic                  r;
        int                    requests_sent;
        int                    phase_no;
        int                    phase_len;
        int                    i;
        bit                    calm;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_CYCLE_COUNT;
        cfg_data           = '0;
        sample_req.valid   = 1'b0;
        sample_req.restart = 1'b0;
        cycle_count_q      = 9'd1;
        amplitude_q        = 11'd511;
        frame_pos          = '0;
        for (i = 0; i < TABLE_STEPS; i++)
            sine_lut[i] = sine_q15(i);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: defaults, one-sample cycles, zero amplitude, empty frames,
        // four-sample cycles at full amplitude, then odd cycle lengths
        directed_rows = {
            item_row(1'b1),
            item_row(1'b0),
            cfg_row(CFG_CYCLE_COUNT, 11'd256),
            cfg_row(CFG_WAVE_AMPLITUDE, 11'd2047),
            typed_row(1'b1, 2047, 0, 1'b1, 1'b0),
            typed_row(1'b0, 2047, 1, 1'b1, 1'b0),
            cfg_row(CFG_WAVE_AMPLITUDE, 11'd0),
            typed_row(1'b0, 0, 2, 1'b1, 1'b0),
            cfg_row(CFG_CYCLE_COUNT, 11'd0),
            typed_row(1'b0, 0, 3, 1'b0, 1'b0),
            cfg_row(CFG_CYCLE_COUNT, 11'h7FF),
            typed_row(1'b0, 0, 4, 1'b0, 1'b0),
            cfg_row(CFG_CYCLE_COUNT, 11'h501),
            typed_row(1'b0, 0, 5, 1'b0, 1'b0),
            cfg_row(CFG_CYCLE_COUNT, 11'd64),
            cfg_row(CFG_WAVE_AMPLITUDE, 11'd2047),
            typed_row(1'b1, 4094, 0, 1'b1, 1'b0),
            typed_row(1'b0, 2047, 1, 1'b1, 1'b0),
            typed_row(1'b0, 0, 2, 1'b1, 1'b0),
            typed_row(1'b0, 2047, 3, 1'b1, 1'b0),
            cfg_row(CFG_CYCLE_COUNT, 11'd3),
            cfg_row(CFG_WAVE_AMPLITUDE, 11'd1234),
            item_row(1'b0),
            item_row(1'b0),
            item_row(1'b0),
            item_row(1'b0),
            cfg_row(CFG_CYCLE_COUNT, 11'h655),
            item_row(1'b0),
            item_row(1'b0),
            cfg_row(CFG_WAVE_AMPLITUDE, 11'd1),
            item_row(1'b0)
        };

        rsp_idle_en   = 1'b1;
        requests_sent = 0;
        foreach (directed_rows[j])
        begin
            row = directed_rows[j];
            if (row.is_cfg)
                write_register(row.reg_idx, row.data);
            else
            begin
                send_request(row.restart, row.typed, row.word);
                requests_sent++;
            end
        end

        // Random phases: new settings, then a run of requests mostly continuing the frame
        phase_no = 0;
        while (requests_sent < TOTAL_REQUESTS)
        begin
            calm        = requests_sent >= TOTAL_REQUESTS - CALM_TAIL;
            snd_idle_en = !calm && $urandom_range(0, 3) != 0;
            rsp_idle_en = !calm && $urandom_range(0, 3) != 0;

            if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 7))
                    0:       d = '0;
                    1:       d = 11'd256;
                    2:       d = 11'(257 + $urandom_range(0, 254));
                    3:       d = 11'd1;
                    default: d = 11'($urandom_range(1, 256));
                endcase
                d[10:9] = 2'($urandom_range(0, 3));
                write_register(CFG_CYCLE_COUNT, d);
            end
            if ($urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 5))
                    0:       d = 11'd0;
                    1:       d = 11'd2047;
                    default: d = 11'($urandom_range(0, 2047));
                endcase
                write_register(CFG_WAVE_AMPLITUDE, d);
            end

            // Fill the block against a stalled receiver
            if (phase_no == 1)
            begin
                snd_idle_en   = 1'b0;
                long_hold_req = 1'b1;
            end

            phase_len = $urandom_range(16, 300);
            for (i = 0; i < phase_len && requests_sent < TOTAL_REQUESTS; i++)
            begin
                // Stop all idling for the last part of the run
                if (requests_sent >= TOTAL_REQUESTS - CALM_TAIL)
                begin
                    snd_idle_en = 1'b0;
                    rsp_idle_en = 1'b0;
                end
                if (phase_no == 2 && i == phase_len / 2)
                    drain_samples();
                sender_gap();
                if (i == 0)
                    r = 1'($urandom_range(0, 1));
                else
                    r = ($urandom_range(0, 199) == 0);
                send_request(r, 1'b0, '0);
                requests_sent++;
            end
            phase_no++;
        end

        drain_samples();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_samples.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
